[rtl/core/cstok_pkg.sv]
`default_nettype none
package cstok_pkg;

  localparam int unsigned MAX_TOKEN_LEN_DEF = 255;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;

  typedef enum logic [2:0] {
    K_BYTE    = 3'd0,
    K_END     = 3'd1,
    K_LONG    = 3'd2,
    K_BADESC  = 3'd3,
    K_EOFSTR  = 3'd4,
    K_EOFNONE = 3'd5
  } kind_t;

  typedef enum logic [7:0] {
    M_SEEK  = 8'b0000_0001,
    M_LINE  = 8'b0000_0010,
    M_BLOCK = 8'b0000_0100,
    M_STAR  = 8'b0000_1000,
    M_SLASH = 8'b0001_0000,
    M_STR   = 8'b0010_0000,
    M_ESC   = 8'b0100_0000,
    M_BARE  = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic [7:0] token_length;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

endpackage
`default_nettype wire

[rtl/core/cstok_if.sv]
`default_nettype none
interface cstok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface cstok_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] out_byte;
  logic [7:0] token_length;

  modport source (output valid, output kind, output out_byte, output token_length,
                  input ready);
  modport sink   (input valid, input kind, input out_byte, input token_length,
                  output ready);
endinterface
`default_nettype wire

[rtl/core/cstok_step.sv]
`default_nettype none
module cstok_step #(
  parameter int unsigned MAX_TOKEN_LEN = cstok_pkg::MAX_TOKEN_LEN_DEF,
  localparam int unsigned CW = $clog2(MAX_TOKEN_LEN + 1)
) (
  input  cstok_pkg::mode_t   mode,
  input  logic [CW-1:0]      count,
  input  logic [7:0]         in_byte,
  input  logic               end_of_input,
  output cstok_pkg::mode_t   mode_next,
  output logic [CW-1:0]      count_next,
  output logic               res_valid,
  output cstok_pkg::result_t res
);
  import cstok_pkg::*;

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TOKEN_LEN);

  logic          at_max;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] len_count;
  logic [16:0]   len_ext;
  kind_t         kind;
  logic [7:0]    obyte;

  assign at_max    = (count >= MAX_CNT);
  assign count_inc = count + CW'(1);

  always_comb begin
    mode_next  = mode;
    count_next = count;
    res_valid  = 1'b0;
    kind       = K_BYTE;
    obyte      = 8'd0;
    if (end_of_input) begin
      res_valid  = 1'b1;
      mode_next  = M_SEEK;
      count_next = '0;
      if (mode == M_BARE) begin
        kind = K_END;
      end else if (mode == M_STR || mode == M_ESC) begin
        kind = K_EOFSTR;
      end else begin
        kind = K_EOFNONE;
      end
    end else begin
      unique case (mode)
        M_LINE: begin
          if (in_byte == CH_LF) mode_next = M_SEEK;
        end
        M_BLOCK: begin
          if (in_byte == CH_STAR) mode_next = M_STAR;
        end
        M_STAR: begin
          if (in_byte == CH_SLASH) mode_next = M_SEEK;
          else if (in_byte != CH_STAR) mode_next = M_BLOCK;
        end
        M_SLASH: begin
          if (in_byte == CH_STAR) mode_next = M_BLOCK;
          else if (in_byte == CH_SLASH) mode_next = M_LINE;
          else mode_next = M_SEEK;
        end
        M_STR: begin
          if (in_byte == CH_QUOTE) begin
            res_valid  = 1'b1;
            kind       = K_END;
            mode_next  = M_SEEK;
            count_next = '0;
          end else if (at_max) begin
            res_valid  = 1'b1;
            kind       = K_LONG;
            mode_next  = M_SEEK;
            count_next = '0;
          end else if (in_byte == CH_BSLASH) begin
            mode_next = M_ESC;
          end else begin
            res_valid  = 1'b1;
            obyte      = in_byte;
            count_next = count_inc;
          end
        end
        M_ESC: begin
          if (in_byte == CH_N || in_byte == CH_T || in_byte == CH_QUOTE
              || in_byte == CH_BSLASH) begin
            res_valid  = 1'b1;
            mode_next  = M_STR;
            count_next = count_inc;
            if (in_byte == CH_N) obyte = CH_LF;
            else if (in_byte == CH_T) obyte = CH_TAB;
            else obyte = in_byte;
          end else begin
            res_valid  = 1'b1;
            kind       = K_BADESC;
            mode_next  = M_SEEK;
            count_next = '0;
          end
        end
        M_BARE: begin
          if (is_ws(in_byte) || at_max) begin
            res_valid  = 1'b1;
            kind       = is_ws(in_byte) ? K_END : K_LONG;
            mode_next  = M_SEEK;
            count_next = '0;
          end else begin
            res_valid  = 1'b1;
            obyte      = in_byte;
            count_next = count_inc;
          end
        end
        default: begin
          // seeking a token start
          count_next = '0;
          mode_next  = M_SEEK;
          if (is_ws(in_byte)) begin
            mode_next = M_SEEK;
          end else if (in_byte == CH_HASH) begin
            mode_next = M_LINE;
          end else if (in_byte == CH_SLASH) begin
            mode_next = M_SLASH;
          end else if (in_byte == CH_QUOTE) begin
            mode_next = M_STR;
          end else begin
            res_valid  = 1'b1;
            obyte      = in_byte;
            mode_next  = M_BARE;
            count_next = CW'(1);
          end
        end
      endcase
    end
  end

  // a byte beat reports the count including itself, an end or error beat the count so far
  assign len_count = (kind == K_BYTE) ? count_next : count;
  assign len_ext   = 17'(len_count);

  always_comb begin
    res.kind     = kind;
    res.out_byte = obyte;
    if (kind == K_EOFNONE) res.token_length = 8'd0;
    else if (len_ext > 17'd255) res.token_length = 8'hFF;
    else res.token_length = len_ext[7:0];
  end

endmodule
`default_nettype wire

[rtl/core/comment_skipping_tokenizer.sv]
`default_nettype none
// Streaming tokenizer: one text byte per beat on din, one token byte or
// status beat on dout. Whitespace, '#' and '//' line comments and block
// comments are skipped; tokens are bare or double-quoted with \" \\ \n \t
// escapes. Each token byte is a beat of kind 0, and the token closes with
// an end or error beat. Throughput is one input byte per cycle while not
// stalled; a byte passes an input register and then the result register
// before its result is valid on dout. Input stalls only while the result
// register holds an untaken beat and the byte in the input register would
// produce another.
module comment_skipping_tokenizer #(
  parameter int unsigned MAX_TOKEN_LEN = cstok_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst,
  cstok_in_if.sink  din,
  cstok_out_if.source dout
);
  import cstok_pkg::*;

  localparam int unsigned CW = $clog2(MAX_TOKEN_LEN + 1);

  logic          s1_valid;
  logic [7:0]    s1_byte;
  logic          s1_eoi;
  mode_t         mode;
  mode_t         mode_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          res_valid;
  result_t       res;
  logic          out_valid;
  result_t       out_res;
  logic          s1_go;

  cstok_step #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_step (
    .mode         (mode),
    .count        (count),
    .in_byte      (s1_byte),
    .end_of_input (s1_eoi),
    .mode_next    (mode_next),
    .count_next   (count_next),
    .res_valid    (res_valid),
    .res          (res)
  );

  // a beat that yields no result may retire even while dout is stalled
  assign s1_go     = s1_valid && (!res_valid || !out_valid || dout.ready);
  assign din.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (din.ready) begin
      s1_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.ready && din.valid) begin
      s1_byte <= din.in_byte;
      s1_eoi  <= din.end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_SEEK;
      count <= '0;
    end else if (s1_go) begin
      mode  <= mode_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && res_valid) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_valid) begin
      out_res <= res;
    end
  end

  assign dout.valid        = out_valid;
  assign dout.kind         = out_res.kind;
  assign dout.out_byte     = out_res.out_byte;
  assign dout.token_length = out_res.token_length;

endmodule
`default_nettype wire
